### hdl/aarm_pkg.sv
// ----------------------------------------------------------------------------
// aarm_pkg: shared types and constants for the axis-angle rotation block
// Item structs, multiplier request/response, angle constants and index maps.
// ----------------------------------------------------------------------------
package aarm_pkg;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
        logic signed [31:0] row_c0;
        logic signed [31:0] row_c1;
        logic signed [31:0] row_c2;
        logic signed [31:0] row_c3;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_c0;
        logic signed [31:0] out_c1;
        logic signed [31:0] out_c2;
        logic signed [31:0] out_c3;
        logic               saturated;
    } t_out_item;

    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int TAG_W   = 5;

    typedef struct packed {
        logic                       valid;
        logic [TAG_W-1:0]           tag;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } t_mul_req;

    typedef struct packed {
        logic                       valid;
        logic [TAG_W-1:0]           tag;
        logic signed [MUL_P_W-1:0]  p;
    } t_mul_rsp;

    typedef enum logic [1:0] {
        SG_NONE,
        SG_POS,
        SG_NEG
    } t_sterm;

    localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
    localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
    localparam logic signed [19:0] ONE_Q16     = 20'sd65536;
    localparam logic signed [17:0] ENT_ONE     = 18'sd65536;
    localparam logic signed [55:0] ENT_HI      = 56'sd131071;
    localparam logic signed [55:0] ENT_LO      = -56'sd131072;

    function automatic logic signed [33:0] atan_q28(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:    v = 34'sd210828714;
            5'd1:    v = 34'sd124459457;
            5'd2:    v = 34'sd65760959;
            5'd3:    v = 34'sd33381290;
            5'd4:    v = 34'sd16755422;
            5'd5:    v = 34'sd8385879;
            5'd6:    v = 34'sd4193963;
            5'd7:    v = 34'sd2097109;
            5'd8:    v = 34'sd1048571;
            5'd9:    v = 34'sd524287;
            5'd10:   v = 34'sd262144;
            5'd11:   v = 34'sd131072;
            5'd12:   v = 34'sd65536;
            5'd13:   v = 34'sd32768;
            5'd14:   v = 34'sd16384;
            5'd15:   v = 34'sd8192;
            5'd16:   v = 34'sd4096;
            5'd17:   v = 34'sd2048;
            5'd18:   v = 34'sd1024;
            5'd19:   v = 34'sd512;
            5'd20:   v = 34'sd256;
            5'd21:   v = 34'sd128;
            5'd22:   v = 34'sd64;
            5'd23:   v = 34'sd32;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // Rotation entry e = 3*i + j uses t*u_i*u_j and the cross term s*u_k.
    function automatic logic [1:0] ent_i(input logic [3:0] e);
        logic [1:0] v;
        unique case (e)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd6: v = 2'd0;
            4'd4, 4'd5, 4'd7:             v = 2'd1;
            default:                      v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] ent_j(input logic [3:0] e);
        logic [1:0] v;
        unique case (e)
            4'd0:                   v = 2'd0;
            4'd1, 4'd3, 4'd4:       v = 2'd1;
            default:                v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] ent_k(input logic [3:0] e);
        logic [1:0] v;
        unique case (e)
            4'd1, 4'd3: v = 2'd2;
            4'd2, 4'd6: v = 2'd1;
            default:    v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic t_sterm ent_sgn(input logic [3:0] e);
        t_sterm v;
        unique case (e)
            4'd1, 4'd5, 4'd6: v = SG_NEG;
            4'd2, 4'd3, 4'd7: v = SG_POS;
            default:          v = SG_NONE;
        endcase
        return v;
    endfunction

    function automatic logic signed [17:0] ent_ident(input logic [3:0] e);
        return (e == 4'd0 || e == 4'd4 || e == 4'd8) ? ENT_ONE : 18'sd0;
    endfunction

    // Row products run column by column: m = 3*j + i.
    function automatic logic [1:0] row_i(input logic [3:0] m);
        logic [1:0] v;
        unique case (m)
            4'd0, 4'd3, 4'd6: v = 2'd0;
            4'd1, 4'd4, 4'd7: v = 2'd1;
            default:          v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] row_j(input logic [3:0] m);
        logic [1:0] v;
        unique case (m)
            4'd0, 4'd1, 4'd2: v = 2'd0;
            4'd3, 4'd4, 4'd5: v = 2'd1;
            default:          v = 2'd2;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] rot_idx(input logic [3:0] m);
        logic [3:0] v;
        unique case (m)
            4'd0:    v = 4'd0;
            4'd1:    v = 4'd3;
            4'd2:    v = 4'd6;
            4'd3:    v = 4'd1;
            4'd4:    v = 4'd4;
            4'd5:    v = 4'd7;
            4'd6:    v = 4'd2;
            4'd7:    v = 4'd5;
            default: v = 4'd8;
        endcase
        return v;
    endfunction

endpackage

### hdl/aarm_mul.sv
// ----------------------------------------------------------------------------
// aarm_mul: shared signed multiplier
// One 36x18 signed product per cycle, registered, with the request tag.
// ----------------------------------------------------------------------------
module aarm_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aarm_pkg::t_mul_req i_req,
    output aarm_pkg::t_mul_rsp o_rsp
);
    import aarm_pkg::*;

    t_mul_rsp r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp.valid <= 1'b0;
        end else begin
            r_rsp.valid <= i_req.valid;
        end
        r_rsp.tag <= i_req.tag;
        r_rsp.p   <= MUL_P_W'(i_req.a * i_req.b);
    end

    assign o_rsp = r_rsp;

endmodule

### hdl/axis_angle_rotate_matrix_top.sv
// ----------------------------------------------------------------------------
// axis_angle_rotate_matrix_top: axis-angle rotation of model matrix rows
// Builds a 3x3 rotation from angle and axis, then rotates model rows by it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------
//  in      | to block  | i_in_valid / o_in_stall | i_in_data  (t_in_item)
//  out     | from block| o_out_valid / i_out_stall| o_out_data (t_out_item)
//
//  A row item runs nine products through the one shared multiplier,
//  between the load and the result hand-off. A set-rotation item runs
//  the CORDIC steps, the square root, three divides, the t*u products
//  and the entry products; a zero axis ends after the norm check. The
//  block stalls its input while an item is at work.
//  Reset (synchronous) restores the identity rotation and empties the output
//  register. A finished result waits in the output register while a new
//  item is taken; the sequencer holds only if that register is still full.
// ----------------------------------------------------------------------------
module axis_angle_rotate_matrix_top #(
    parameter int DATA_WIDTH   = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aarm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aarm_pkg::t_out_item o_out_data
);
    import aarm_pkg::*;

    localparam int OUT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int STEPS_USED = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam logic [4:0] LAST_STEP = 5'(STEPS_USED - 1);
    localparam logic signed [55:0] SAT_HI = (56'sd1 <<< (OUT_BITS - 1)) - 56'sd1;
    localparam logic signed [55:0] SAT_LO = -SAT_HI - 56'sd1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ZCHK, S_WRAP, S_HALF, S_CORD, S_CS,
        S_SQRT, S_DSET, S_DIV, S_TU, S_ENT, S_ROW, S_OUT
    } t_state;

    t_state                r_state;
    logic [4:0]            r_cnt;
    logic [1:0]            r_k;
    t_in_item              r_item;
    logic [33:0]           r_n2;
    logic signed [33:0]    r_z, r_x, r_y;
    logic                  r_neg;
    logic signed [19:0]    r_c, r_s, r_t;
    logic [63:0]           r_sq_n, r_sq_res, r_sq_bit;
    logic [48:0]           r_rem, r_dsh;
    logic [17:0]           r_q;
    logic signed [17:0]    r_u   [3];
    logic signed [35:0]    r_tu  [3];
    logic signed [55:0]    r_acc;
    logic signed [17:0]    r_rot [9];
    logic signed [31:0]    r_res [3];
    logic                  r_sat;
    logic                  r_out_valid;
    t_out_item             r_out_data;

    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;

    aarm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Axis component and row entry selection.
    function automatic logic signed [15:0] axis_sel(input t_in_item it, input logic [1:0] k);
        logic signed [15:0] v;
        unique case (k)
            2'd0:    v = it.axis_x;
            2'd1:    v = it.axis_y;
            default: v = it.axis_z;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] row_sel(input t_in_item it, input logic [1:0] i);
        logic signed [31:0] v;
        unique case (i)
            2'd0:    v = it.row_c0;
            2'd1:    v = it.row_c1;
            default: v = it.row_c2;
        endcase
        return v;
    endfunction

    // Multiplier operand selection.
    logic [3:0] ent_e;
    logic [3:0] row_m;
    assign ent_e = r_cnt[4:1];
    assign row_m = r_cnt[3:0];

    always_comb begin
        mul_req.valid = 1'b0;
        mul_req.tag   = r_cnt;
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (r_state)
            S_SQ: begin
                mul_req.valid = (r_cnt < 5'd3);
                mul_req.a     = MUL_A_W'(axis_sel(r_item, r_cnt[1:0]));
                mul_req.b     = MUL_B_W'(axis_sel(r_item, r_cnt[1:0]));
            end
            S_TU: begin
                mul_req.valid = (r_cnt < 5'd3);
                mul_req.a     = MUL_A_W'(r_t);
                mul_req.b     = r_u[r_cnt[1:0]];
            end
            S_ENT: begin
                mul_req.valid = (r_cnt < 5'd18);
                if (r_cnt[0]) begin
                    mul_req.a = MUL_A_W'(r_s);
                    mul_req.b = r_u[ent_k(ent_e)];
                end else begin
                    mul_req.a = r_tu[ent_i(ent_e)];
                    mul_req.b = r_u[ent_j(ent_e)];
                end
            end
            S_ROW: begin
                mul_req.valid = (r_cnt < 5'd9);
                mul_req.a     = MUL_A_W'(row_sel(r_item, row_i(row_m)));
                mul_req.b     = r_rot[rot_idx(row_m)];
            end
            default: begin
                mul_req.valid = 1'b0;
            end
        endcase
    end

    // Product arithmetic on the response side.
    logic signed [55:0] p56;
    logic signed [55:0] c_sh;
    logic signed [55:0] s_term;
    logic signed [55:0] e_full, e_rnd;
    logic signed [17:0] e_val;
    logic signed [55:0] r_full, r_rnd;
    logic signed [31:0] r_val;
    logic               r_clip;
    logic [3:0]         rsp_e;
    logic [3:0]         rsp_m;
    logic signed [55:0] c3_ext;
    logic signed [31:0] c3_val;
    logic               c3_clip;

    assign p56   = 56'(mul_rsp.p);
    assign c_sh  = {{4{r_c[19]}}, r_c, 32'd0};
    assign rsp_e = mul_rsp.tag[4:1];
    assign rsp_m = mul_rsp.tag[3:0];

    always_comb begin
        unique case (ent_sgn(rsp_e))
            SG_NEG:  s_term = -p56;
            SG_POS:  s_term = p56;
            default: s_term = '0;
        endcase
        e_full = r_acc + (s_term <<< 16);
        e_rnd  = (e_full + 56'sd2147483648) >>> 32;
        if (e_rnd > ENT_HI) begin
            e_val = 18'sd131071;
        end else if (e_rnd < ENT_LO) begin
            e_val = -18'sd131072;
        end else begin
            e_val = e_rnd[17:0];
        end

        r_full = ((row_i(rsp_m) == 2'd0) ? 56'sd0 : r_acc) + p56;
        r_rnd  = (r_full + 56'sd32768) >>> 16;
        r_clip = 1'b0;
        if (r_rnd > SAT_HI) begin
            r_val  = SAT_HI[31:0];
            r_clip = 1'b1;
        end else if (r_rnd < SAT_LO) begin
            r_val  = SAT_LO[31:0];
            r_clip = 1'b1;
        end else begin
            r_val = r_rnd[31:0];
        end

        c3_ext  = 56'(r_item.row_c3);
        c3_clip = 1'b0;
        if (c3_ext > SAT_HI) begin
            c3_val  = SAT_HI[31:0];
            c3_clip = 1'b1;
        end else if (c3_ext < SAT_LO) begin
            c3_val  = SAT_LO[31:0];
            c3_clip = 1'b1;
        end else begin
            c3_val = r_item.row_c3;
        end
    end

    // Square root and divide steps, and cos and sin rounding.
    logic [64:0]        sq_sum;
    logic               sq_ge;
    logic               dv_ge;
    logic [17:0]        dv_q;
    logic signed [15:0] a_k;
    logic [16:0]        a_abs;
    logic signed [19:0] c_v, s_v;
    logic signed [33:0] c_rnd, s_rnd;

    assign sq_sum = {1'b0, r_sq_res} + {1'b0, r_sq_bit};
    assign sq_ge  = {1'b0, r_sq_n} >= sq_sum;
    assign dv_ge  = r_rem >= r_dsh;
    assign dv_q   = {r_q[16:0], dv_ge};
    assign a_k    = axis_sel(r_item, r_k);
    assign a_abs  = a_k[15] ? -17'(a_k) : 17'(a_k);
    assign c_rnd  = (r_x + 34'sd8192) >>> 14;
    assign s_rnd  = (r_y + 34'sd8192) >>> 14;
    assign c_v    = r_neg ? -c_rnd[19:0] : c_rnd[19:0];
    assign s_v    = r_neg ? -s_rnd[19:0] : s_rnd[19:0];

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < 9; e++) begin
                r_rot[e] <= ent_ident(4'(e));
            end
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_cnt  <= '0;
                        r_n2   <= '0;
                        r_sat  <= 1'b0;
                        r_state <= i_in_data.operation ? S_ROW : S_SQ;
                    end
                end
                S_SQ: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (mul_rsp.valid) begin
                        r_n2 <= r_n2 + 34'(mul_rsp.p[31:0]);
                    end
                    if (r_cnt == 5'd3) begin
                        r_state <= S_ZCHK;
                    end
                end
                S_ZCHK: begin
                    // Zero axis: load the identity and finish.
                    if (r_n2 == '0) begin
                        for (int e = 0; e < 9; e++) begin
                            r_rot[e] <= ent_ident(4'(e));
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_z      <= 34'($signed({r_item.angle, 16'd0}));
                        r_sq_n   <= {r_n2[31:0], 32'd0};
                        r_sq_res <= '0;
                        r_sq_bit <= 64'h4000_0000_0000_0000;
                        r_state  <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (r_z > PI_Q28) begin
                        r_z <= r_z - TWO_PI_Q28;
                    end else if (r_z < -PI_Q28) begin
                        r_z <= r_z + TWO_PI_Q28;
                    end
                    r_state <= S_HALF;
                end
                S_HALF: begin
                    // Fold into the right half plane; negate cos and sin later.
                    if (r_z > HALF_PI_Q28) begin
                        r_z   <= r_z - PI_Q28;
                        r_neg <= 1'b1;
                    end else if (r_z < -HALF_PI_Q28) begin
                        r_z   <= r_z + PI_Q28;
                        r_neg <= 1'b1;
                    end else begin
                        r_neg <= 1'b0;
                    end
                    r_x     <= CORDIC_X0;
                    r_y     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_CORD;
                end
                S_CORD: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - (r_y >>> r_cnt);
                        r_y <= r_y + (r_x >>> r_cnt);
                        r_z <= r_z - atan_q28(r_cnt);
                    end else begin
                        r_x <= r_x + (r_y >>> r_cnt);
                        r_y <= r_y - (r_x >>> r_cnt);
                        r_z <= r_z + atan_q28(r_cnt);
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= S_CS;
                    end
                end
                S_CS: begin
                    r_c     <= c_v;
                    r_s     <= s_v;
                    r_t     <= ONE_Q16 - c_v;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_ge) begin
                        r_sq_n   <= r_sq_n - sq_sum[63:0];
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_cnt    <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_k     <= '0;
                        r_state <= S_DSET;
                    end
                end
                S_DSET: begin
                    // Dividend |a| * 2^32 plus half the root for rounding.
                    r_rem   <= 49'({a_abs[15:0], 32'd0}) + 49'(r_sq_res[31:1]);
                    r_dsh   <= {r_sq_res[31:0], 17'd0};
                    r_q     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (dv_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_dsh <= r_dsh >> 1;
                    r_q   <= dv_q;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd17) begin
                        r_u[r_k] <= a_k[15] ? -dv_q : dv_q;
                        if (r_k == 2'd2) begin
                            r_cnt   <= '0;
                            r_state <= S_TU;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DSET;
                        end
                    end
                end
                S_TU: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (mul_rsp.valid) begin
                        r_tu[mul_rsp.tag[1:0]] <= mul_rsp.p[35:0];
                    end
                    if (r_cnt == 5'd3) begin
                        r_cnt   <= '0;
                        r_state <= S_ENT;
                    end
                end
                S_ENT: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (mul_rsp.valid) begin
                        if (!mul_rsp.tag[0]) begin
                            r_acc <= ((ent_sgn(rsp_e) == SG_NONE) ? c_sh : 56'sd0) + p56;
                        end else begin
                            r_rot[rsp_e] <= e_val;
                        end
                    end
                    if (r_cnt == 5'd18) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ROW: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (mul_rsp.valid) begin
                        r_acc <= r_full;
                        if (row_i(rsp_m) == 2'd2) begin
                            r_res[row_j(rsp_m)] <= r_val;
                            r_sat               <= r_sat | r_clip;
                        end
                    end
                    if (r_cnt == 5'd9) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out_data.out_c0    <= r_res[0];
                        r_out_data.out_c1    <= r_res[1];
                        r_out_data.out_c2    <= r_res[2];
                        r_out_data.out_c3    <= c3_val;
                        r_out_data.saturated <= r_sat | c3_clip;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### hdl/aarm_chk.sv
// ----------------------------------------------------------------------------
// aarm_chk: port-level checks for the axis-angle rotation block
// Watches handshakes, set-rotation results and reset on the top level ports.
// ----------------------------------------------------------------------------
module aarm_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input aarm_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input aarm_pkg::t_out_item o_out_data
);
    import aarm_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output item changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input taken while an item is at work");

    a_no_result_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_in_data.operation && !o_out_valid |=> !o_out_valid)
        else $error("set-rotation item produced a result");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not empty the block");

endmodule

bind axis_angle_rotate_matrix_top aarm_chk u_aarm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for axis_angle_rotate_matrix_top
// Drives set-rotation and row items in random bursts against a stalling
// receiver. A built-in fixed-point model predicts each rotated row, and the
// bench compares every field of each result in order.
// ----------------------------------------------------------------------------
module testbench;
    import aarm_pkg::*;

    localparam int  OP_SET_ROT = 0;
    localparam int  OP_ROW     = 1;
    localparam int  N_RANDOM   = 830;
    localparam int  TAIL_WAIT  = 400;   // covers the longest set-rotation item
    localparam longint PI28    = 843314857;
    localparam longint TWOPI28 = 1686629713;
    localparam longint HPI28   = 421657428;
    localparam longint X0_Q30  = 652032874;
    localparam longint ONE16   = 65536;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    axis_angle_rotate_matrix_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    t_in_item  items_pending[$];
    t_out_item rows_expected[$];
    longint    rot_q16[9];          // predicted rotation, Q1.16
    int        mismatches = 0;
    int        burst_left = 4;
    int        gap_left   = 0;
    int        stall_mode = 0;
    int        stall_cnt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("axis_angle_rotate_matrix_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Fixed-point prediction
    // ------------------------------------------------------------------
    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_axis(input longint a, input longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = longint'(a < 0 ? -a : a) << 32;
        q   = longint'((mag + r / 2) / r);
        return a < 0 ? -q : q;
    endfunction

    function automatic longint rot_entry(input longint dc, input longint t,
                                         input longint ui, input longint uj,
                                         input longint st);
        longint e;
        e = dc * 64'sd4294967296 + t * ui * uj + st * ONE16;
        e = (e + 64'sd2147483648) >>> 32;
        if (e > 131071)  e = 131071;
        if (e < -131072) e = -131072;
        return e;
    endfunction

    function automatic void load_rotation(input t_in_item it);
        longint ax, ay, az, z, x, y, nx, c, s, t, ux, uy, uz;
        longint unsigned n2, r;
        bit neg;
        ax = it.axis_x;
        ay = it.axis_y;
        az = it.axis_z;
        n2 = ax * ax + ay * ay + az * az;
        if (n2 == 0) begin
            // zero axis: fall back to identity
            for (int k = 0; k < 9; k++) rot_q16[k] = (k % 4 == 0) ? ONE16 : 0;
            return;
        end
        z   = longint'(it.angle) * 65536;
        x   = X0_Q30;
        y   = 0;
        neg = 1'b0;
        if (z > PI28) z = z - TWOPI28;
        else if (z < -PI28) z = z + TWOPI28;
        if (z > HPI28) begin
            z = z - PI28; neg = 1'b1;
        end else if (z < -HPI28) begin
            z = z + PI28; neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_q28(5'(i)));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_q28(5'(i)));
            end
            x = nx;
        end
        c = (x + 8192) >>> 14;
        s = (y + 8192) >>> 14;
        if (neg) begin
            c = -c; s = -s;
        end
        r  = root_floor(n2 << 32);
        ux = unit_axis(ax, r);
        uy = unit_axis(ay, r);
        uz = unit_axis(az, r);
        t  = ONE16 - c;
        rot_q16[0] = rot_entry(c, t, ux, ux, 0);
        rot_q16[1] = rot_entry(0, t, ux, uy, -s * uz);
        rot_q16[2] = rot_entry(0, t, ux, uz, s * uy);
        rot_q16[3] = rot_entry(0, t, ux, uy, s * uz);
        rot_q16[4] = rot_entry(c, t, uy, uy, 0);
        rot_q16[5] = rot_entry(0, t, uy, uz, -s * ux);
        rot_q16[6] = rot_entry(0, t, ux, uz, -s * uy);
        rot_q16[7] = rot_entry(0, t, uy, uz, s * ux);
        rot_q16[8] = rot_entry(c, t, uz, uz, 0);
    endfunction

    function automatic longint clip32(input longint v, inout bit flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1; return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1; return -64'sd2147483648;
        end
        return v;
    endfunction

    // Update the rotation or queue the rotated row for one accepted item.
    function automatic void rotate_predict(input t_in_item it);
        longint row[3], sum, v[4];
        bit flag;
        t_out_item res;
        if (it.operation == 1'(OP_SET_ROT)) begin
            load_rotation(it);
            return;
        end
        flag   = 1'b0;
        row[0] = it.row_c0;
        row[1] = it.row_c1;
        row[2] = it.row_c2;
        for (int j = 0; j < 3; j++) begin
            sum = 0;
            for (int i = 0; i < 3; i++) sum = sum + row[i] * rot_q16[i * 3 + j];
            v[j] = clip32((sum + 32768) >>> 16, flag);
        end
        v[3] = clip32(longint'(it.row_c3), flag);
        res.out_c0    = v[0][31:0];
        res.out_c1    = v[1][31:0];
        res.out_c2    = v[2][31:0];
        res.out_c3    = v[3][31:0];
        res.saturated = flag;
        rows_expected.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Driver: send queued items in bursts, hold payload while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) rotate_predict(items_pending.pop_front());
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (items_pending.size() > 0) begin
                i_in_valid <= 1'b1;
                i_in_data  <= items_pending[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    // leave some bursts back to back
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall pattern: free, light or heavy, switching every so often
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_cnt == 0) begin
                stall_mode <= $urandom_range(0, 2);
                stall_cnt  <= $urandom_range(20, 150);
            end else begin
                stall_cnt <= stall_cnt - 1;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 9) < 3);
                default: i_out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rows_expected.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected result %p", o_out_data);
            end else if (o_out_data !== rows_expected[0]) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("row mismatch: expected %p actual %p",
                             rows_expected[0], o_out_data);
                void'(rows_expected.pop_front());
            end else begin
                void'(rows_expected.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic t_in_item make_rot(input logic [15:0] ang, input logic [15:0] x,
                                          input logic [15:0] y, input logic [15:0] z);
        t_in_item it;
        it           = '0;
        it.operation = 1'(OP_SET_ROT);
        it.angle     = ang;
        it.axis_x    = x;
        it.axis_y    = y;
        it.axis_z    = z;
        it.row_c0    = $urandom;    // ignored fields still toggle
        it.row_c3    = $urandom;
        return it;
    endfunction

    function automatic t_in_item make_row(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        t_in_item it;
        it           = '0;
        it.operation = 1'(OP_ROW);
        it.angle     = 16'($urandom);
        it.axis_x    = 16'($urandom);
        it.row_c0    = a;
        it.row_c1    = b;
        it.row_c2    = c;
        it.row_c3    = d;
        return it;
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(0, 2 * 655360)) - 655360);
            2:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2 * 65536)) - 65536);
        endcase
    endfunction

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        for (int k = 0; k < 9; k++) rot_q16[k] = (k % 4 == 0) ? ONE16 : 0;

        // identity after reset, field extremes and saturation
        items_pending.push_back(make_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                         32'h8000_0000));
        items_pending.push_back(make_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                                         32'h7FFF_FFFF));
        // quarter turn about z: a negative extreme flips and clips
        items_pending.push_back(make_rot(16'sd6434, 16'sd0, 16'sd0, 16'sd1));
        items_pending.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h0000_0000,
                                         32'h0000_1234));
        items_pending.push_back(make_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0));
        // angle extremes and axis extremes
        items_pending.push_back(make_rot(16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
        items_pending.push_back(make_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        items_pending.push_back(make_rot(16'h8000, 16'h7FFF, 16'h0000, 16'h8000));
        items_pending.push_back(make_row(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000, 5));
        items_pending.push_back(make_rot(16'sd0, 16'sd3, 16'sd4, 16'sd5));
        items_pending.push_back(make_row(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 7));
        items_pending.push_back(make_rot(16'sd12868, 16'sd1, 16'sd0, 16'sd0));
        items_pending.push_back(make_row(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0));
        items_pending.push_back(make_rot(-16'sd12868, 16'sd0, -16'sd1, 16'sd0));
        items_pending.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        // zero axis drops back to identity
        items_pending.push_back(make_rot(16'sd3000, 16'sd0, 16'sd0, 16'sd0));
        items_pending.push_back(make_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                                         32'h5555_AAAA));

        // random part: mostly rows under a freshly loaded rotation
        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 9) == 0)
                items_pending.push_back(make_rot(16'($urandom), rand_axis(), rand_axis(),
                                                 rand_axis()));
            else
                items_pending.push_back(make_row(rand_entry(), rand_entry(), rand_entry(),
                                                 rand_entry()));
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (items_pending.size() > 0 || rows_expected.size() > 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (mismatches == 0 && rows_expected.size() == 0)
            $display("axis_angle_rotate_matrix_top: match");
        else
            $display("axis_angle_rotate_matrix_top: mismatch");
        $finish;
    end

endmodule
